>>> hdl/glp_pkg.sv
// Package with shared types and constants of the G-code line parser.
package glp_pkg;

	localparam int MAX_VALUE_CHARS = 63;
	localparam int FRACTION_DIGITS = 3;
	localparam int UNIT_SCALE = 10 ** FRACTION_DIGITS;
	localparam int TLEN_W = 7;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_GO = 3'd0,
		CMD_INCHES = 3'd1,
		CMD_MM = 3'd2,
		CMD_HOME = 3'd3,
		CMD_ABS = 3'd4,
		CMD_REL = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0,
		ERR_UNKNOWN = 3'd1,
		ERR_NUMBER = 3'd2,
		ERR_VALUE = 3'd3,
		ERR_LONG = 3'd4,
		ERR_HOME = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		PH_LETTER,
		PH_NUM_START,
		PH_NUM_DIGITS,
		PH_NUM_STOPPED,
		PH_GAP,
		PH_TOKEN,
		PH_SKIP
	} phase_t;

	// Byte class found by the front end.
	typedef enum logic [2:0] {
		CL_OTHER,
		CL_SPACE,
		CL_WS,
		CL_DIGIT,
		CL_PLUS,
		CL_MINUS,
		CL_DOT
	} cls_t;

	// One classified byte handed from front to back.
	typedef struct packed {
		logic [7:0] ch;
		cls_t cls;
		logic [3:0] digit;
		logic last;
	} tok_t;

	typedef struct packed {
		logic [2:0] command;
		logic x_present;
		logic [31:0] x_value;
		logic y_present;
		logic [31:0] y_value;
		logic z_present;
		logic [31:0] z_value;
		logic f_present;
		logic [31:0] f_value;
		logic [2:0] error;
	} res_t;

	localparam logic [32:0] MAG_CAP = 33'h1_0000_0000 >> 1;

	// Saturate a magnitude at 2^31.
	function automatic logic [32:0] sat_acc(input logic [36:0] r);
		sat_acc = (r > {4'd0, MAG_CAP}) ? MAG_CAP : r[32:0];
	endfunction

endpackage

>>> hdl/glp_if.sv
// Valid/ready channel interfaces for bytes and results.
interface glp_in_if (input logic clk);
	logic valid;
	logic ready;
	logic [7:0] byte_in;
	logic last;
	modport source (output valid, output byte_in, output last, input ready);
	modport sink (input valid, input byte_in, input last, output ready);
endinterface

interface glp_out_if (input logic clk);
	logic valid;
	logic ready;
	logic [2:0] command;
	logic x_present;
	logic signed [31:0] x_value;
	logic y_present;
	logic signed [31:0] y_value;
	logic z_present;
	logic signed [31:0] z_value;
	logic f_present;
	logic signed [31:0] f_value;
	logic [2:0] error;
	modport source (output valid, output command, output x_present, output x_value,
		output y_present, output y_value, output z_present, output z_value,
		output f_present, output f_value, output error, input ready);
	modport sink (input valid, input command, input x_present, input x_value,
		input y_present, input y_value, input z_present, input z_value,
		input f_present, input f_value, input error, output ready);
endinterface

>>> hdl/glp_front.sv
// Front end: accepts bytes and classifies them into a small queue.
module glp_front (
	input logic clk,
	input logic arst_n,
	glp_in_if.sink in_ch,
	output glp_pkg::tok_t tok,
	output logic tok_valid,
	input logic tok_ready
);
	import glp_pkg::*;

	tok_t mem_q [QUEUE_DEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	tok_t cls_tok;
	logic push, pop;

	// Classify the incoming byte.
	always_comb begin
		cls_tok.ch = in_ch.byte_in;
		cls_tok.last = in_ch.last;
		cls_tok.digit = in_ch.byte_in[3:0];
		if (in_ch.byte_in == 8'h20) cls_tok.cls = CL_SPACE;
		else if (in_ch.byte_in inside {[8'd9:8'd13]}) cls_tok.cls = CL_WS;
		else if (in_ch.byte_in inside {[8'h30:8'h39]}) cls_tok.cls = CL_DIGIT;
		else if (in_ch.byte_in == 8'h2B) cls_tok.cls = CL_PLUS;
		else if (in_ch.byte_in == 8'h2D) cls_tok.cls = CL_MINUS;
		else if (in_ch.byte_in == 8'h2E) cls_tok.cls = CL_DOT;
		else cls_tok.cls = CL_OTHER;
	end

	assign in_ch.ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign tok_valid = (cnt_q != 2'd0);
	assign pop = tok_valid && tok_ready;
	assign tok = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cls_tok;
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> hdl/glp_back.sv
// Back end: runs the parse state machine and holds the result register.
module glp_back (
	input logic clk,
	input logic arst_n,
	input glp_pkg::tok_t tok,
	input logic tok_valid,
	output logic tok_ready,
	glp_out_if.source out_ch
);
	import glp_pkg::*;

	phase_t phase_q, phase_d;
	logic [6:0] cnum_q, cnum_d;
	logic nf_digit_q, nf_digit_d, nf_neg_q, nf_neg_d;
	logic [2:0] code_q, code_d;
	logic [7:0] letter_q, letter_d;
	logic [TLEN_W-1:0] tlen_q, tlen_d;
	logic [32:0] acc_q, acc_d;
	logic [2:0] frac_q, frac_d;
	logic vneg_q, vneg_d, vdig_q, vdig_d, vdot_q, vdot_d, vstop_q, vstop_d;
	logic vstart_q, vstart_d;
	logic [3:0] pres_q, pres_d;
	logic [31:0] ax_q [4];
	logic [31:0] ax_d [4];
	logic [2:0] err_q, err_d;
	res_t res_q, res_d;
	logic res_valid_q;
	logic take, emit;
	logic [19:0] wt;
	logic [32:0] acc_int, acc_frac;

	// Only a line's last byte needs the result register to be free.
	assign tok_ready = !res_valid_q || out_ch.ready || !tok.last;
	assign take = tok_valid && tok_ready;

	// The accumulator holds the magnitude already scaled to thousandths: an
	// integer digit shifts it a decade and adds the digit at unit weight, a
	// fraction digit adds the digit at the place that the fraction count names.
	always_comb begin
		case (frac_q)
			3'd0: wt = 20'(10 ** (FRACTION_DIGITS - 1));
			3'd1: wt = 20'(10 ** (FRACTION_DIGITS - 2));
			3'd2: wt = 20'(10 ** (FRACTION_DIGITS - 3));
			3'd3: wt = 20'(10 ** (FRACTION_DIGITS - 4));
			3'd4: wt = 20'(10 ** (FRACTION_DIGITS - 5));
			3'd5: wt = 20'(10 ** (FRACTION_DIGITS - 6));
			default: wt = '0;
		endcase
		acc_int = sat_acc({4'd0, acc_q} * 37'd10 + 37'(tok.digit) * 37'(UNIT_SCALE));
		acc_frac = sat_acc({4'd0, acc_q} + 37'(tok.digit) * {17'd0, wt});
	end

	// Parse state update for one byte, including the end of line.
	always_comb begin
		logic [6:0] nx;
		logic [10:0] nw;
		logic [1:0] axi;
		logic axok, fin_num, fin_tok;
		logic [31:0] vv;
		phase_d = phase_q; cnum_d = cnum_q; nf_digit_d = nf_digit_q; nf_neg_d = nf_neg_q;
		code_d = code_q; letter_d = letter_q; tlen_d = tlen_q; acc_d = acc_q;
		frac_d = frac_q; vneg_d = vneg_q; vdig_d = vdig_q; vdot_d = vdot_q;
		vstop_d = vstop_q; vstart_d = vstart_q; pres_d = pres_q; err_d = err_q;
		for (int i = 0; i < 4; i++) ax_d[i] = ax_q[i];
		fin_num = 1'b0; fin_tok = 1'b0;
		axok = 1'b1; axi = 2'd0;
		vv = '0;
		case (letter_q)
			8'h58: axi = 2'd0;
			8'h59: axi = 2'd1;
			8'h5A: axi = 2'd2;
			8'h46: axi = 2'd3;
			default: axok = 1'b0;
		endcase
		nw = {4'd0, cnum_q} * 11'd10 + {7'd0, tok.digit};
		nx = (nw > 11'd127) ? 7'd127 : nw[6:0];
		case (phase_q)
			PH_LETTER: begin
				if (tok.ch == 8'h47) phase_d = PH_NUM_START;
				else begin
					err_d = ERR_UNKNOWN; phase_d = PH_SKIP;
				end
			end
			PH_NUM_START, PH_NUM_DIGITS, PH_NUM_STOPPED: begin
				if (tok.cls == CL_SPACE) fin_num = 1'b1;
				else if (phase_q == PH_NUM_STOPPED) begin
				end else if (phase_q == PH_NUM_START && tok.cls == CL_WS) begin
				end else if (phase_q == PH_NUM_START && tok.cls == CL_PLUS) begin
					phase_d = PH_NUM_DIGITS;
				end else if (phase_q == PH_NUM_START && tok.cls == CL_MINUS) begin
					phase_d = PH_NUM_DIGITS; nf_neg_d = 1'b1;
				end else if (tok.cls == CL_DIGIT) begin
					phase_d = PH_NUM_DIGITS; nf_digit_d = 1'b1; cnum_d = nx;
				end else phase_d = PH_NUM_STOPPED;
			end
			PH_GAP: begin
				if (tok.cls != CL_SPACE) begin
					letter_d = tok.ch; tlen_d = '0; acc_d = '0; frac_d = '0;
					vneg_d = 1'b0; vdig_d = 1'b0; vdot_d = 1'b0; vstop_d = 1'b0;
					vstart_d = 1'b0; phase_d = PH_TOKEN;
				end
			end
			PH_TOKEN: begin
				if (tok.cls == CL_SPACE) fin_tok = 1'b1;
				else begin
					if (tlen_q != '1) tlen_d = tlen_q + 1'b1;
					if (code_q == CMD_GO && !vstop_q) begin
						if (!vstart_q && tok.cls == CL_WS) begin
						end else if (!vstart_q && tok.cls == CL_PLUS) vstart_d = 1'b1;
						else if (!vstart_q && tok.cls == CL_MINUS) begin
							vstart_d = 1'b1; vneg_d = 1'b1;
						end else begin
							vstart_d = 1'b1;
							if (tok.cls == CL_DIGIT) begin
								vdig_d = 1'b1;
								if (!vdot_q) acc_d = acc_int;
								else if (frac_q < 3'(FRACTION_DIGITS)) begin
									acc_d = acc_frac;
									frac_d = frac_q + 3'd1;
								end
							end else if (tok.cls == CL_DOT && !vdot_q) vdot_d = 1'b1;
							else vstop_d = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		if (tok.last) begin
			if (phase_q == PH_LETTER && tok.ch == 8'h47) fin_num = 1'b1;
			else if (phase_q == PH_GAP && tok.cls != CL_SPACE) begin
				// A one-letter token that ends the line.
				axok = 1'b1;
				case (tok.ch)
					8'h58: axi = 2'd0;
					8'h59: axi = 2'd1;
					8'h5A: axi = 2'd2;
					8'h46: axi = 2'd3;
					default: axok = 1'b0;
				endcase
				if (code_q == CMD_HOME) begin
					if (!axok || axi == 2'd3) begin
						if (err_d == ERR_OK) err_d = ERR_HOME;
					end else begin
						pres_d[axi] = 1'b1; ax_d[axi] = 32'd1000;
					end
				end else if (axok && err_d == ERR_OK) err_d = ERR_VALUE;
			end else if ((phase_q inside {PH_NUM_START, PH_NUM_DIGITS, PH_NUM_STOPPED})
					&& tok.cls != CL_SPACE) fin_num = 1'b1;
			else if (phase_q == PH_TOKEN && tok.cls != CL_SPACE) fin_tok = 1'b1;
		end
		// Close the command number.
		if (fin_num) begin
			if (!nf_digit_d) begin
				if (err_d == ERR_OK) err_d = ERR_NUMBER;
				phase_d = PH_SKIP;
			end else begin
				logic ok;
				ok = 1'b1;
				if (nf_neg_d && cnum_d != 7'd0) ok = 1'b0;
				else begin
					case (cnum_d)
						7'd0, 7'd1: code_d = CMD_GO;
						7'd20: code_d = CMD_INCHES;
						7'd21: code_d = CMD_MM;
						7'd28: code_d = CMD_HOME;
						7'd90: code_d = CMD_ABS;
						7'd91: code_d = CMD_REL;
						default: ok = 1'b0;
					endcase
				end
				if (!ok) begin
					if (err_d == ERR_OK) err_d = ERR_UNKNOWN;
					phase_d = PH_SKIP;
				end else phase_d = (code_d == CMD_GO || code_d == CMD_HOME) ? PH_GAP : PH_SKIP;
			end
		end
		// Close a token; its data are the token state including this byte.
		if (fin_tok) begin
			phase_d = PH_GAP;
			if (code_q == CMD_HOME) begin
				if (!axok || axi == 2'd3 || tlen_d != '0) begin
					if (err_d == ERR_OK) err_d = ERR_HOME;
					phase_d = PH_SKIP;
				end else begin
					pres_d[axi] = 1'b1; ax_d[axi] = 32'd1000;
				end
			end else if (axok) begin
				if (tlen_d > TLEN_W'(MAX_VALUE_CHARS)) begin
					if (err_d == ERR_OK) err_d = ERR_LONG;
					phase_d = PH_SKIP;
				end else if (!vdig_d) begin
					if (err_d == ERR_OK) err_d = ERR_VALUE;
					phase_d = PH_SKIP;
				end else begin
					if (vneg_d) vv = acc_d[32] ? 32'h8000_0000 : (32'd0 - acc_d[31:0]);
					else vv = (acc_d[31] || acc_d[32]) ? 32'h7FFF_FFFF : acc_d[31:0];
					pres_d[axi] = 1'b1; ax_d[axi] = vv;
				end
			end
		end
	end

	assign emit = take && tok.last;

	always_comb begin
		res_d = '0;
		res_d.error = err_d;
		if (err_d == ERR_OK) begin
			res_d.command = code_d;
			res_d.x_present = pres_d[0]; res_d.x_value = ax_d[0];
			res_d.y_present = pres_d[1]; res_d.y_value = ax_d[1];
			res_d.z_present = pres_d[2]; res_d.z_value = ax_d[2];
			res_d.f_present = pres_d[3]; res_d.f_value = ax_d[3];
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LETTER; cnum_q <= '0; nf_digit_q <= 1'b0; nf_neg_q <= 1'b0;
			code_q <= '0; letter_q <= '0; tlen_q <= '0; acc_q <= '0; frac_q <= '0;
			vneg_q <= 1'b0; vdig_q <= 1'b0; vdot_q <= 1'b0; vstop_q <= 1'b0;
			vstart_q <= 1'b0; pres_q <= '0; err_q <= '0;
			for (int i = 0; i < 4; i++) ax_q[i] <= '0;
		end else if (take) begin
			if (emit) begin
				phase_q <= PH_LETTER; cnum_q <= '0; nf_digit_q <= 1'b0; nf_neg_q <= 1'b0;
				code_q <= '0; letter_q <= letter_d; tlen_q <= '0; acc_q <= '0;
				frac_q <= '0; pres_q <= '0;
				vneg_q <= 1'b0; vdig_q <= 1'b0; vdot_q <= 1'b0; vstop_q <= 1'b0;
				vstart_q <= 1'b0; err_q <= '0;
				for (int i = 0; i < 4; i++) ax_q[i] <= '0;
			end else begin
				phase_q <= phase_d; cnum_q <= cnum_d; nf_digit_q <= nf_digit_d;
				nf_neg_q <= nf_neg_d; code_q <= code_d; letter_q <= letter_d;
				tlen_q <= tlen_d; acc_q <= acc_d; frac_q <= frac_d; vneg_q <= vneg_d;
				vdig_q <= vdig_d; vdot_q <= vdot_d; vstop_q <= vstop_d;
				vstart_q <= vstart_d; pres_q <= pres_d; err_q <= err_d;
				for (int i = 0; i < 4; i++) ax_q[i] <= ax_d[i];
			end
		end
	end

	// Result register toward the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (emit) res_valid_q <= 1'b1;
		else if (out_ch.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) res_q <= res_d;
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.command = res_q.command;
	assign out_ch.x_present = res_q.x_present;
	assign out_ch.x_value = res_q.x_value;
	assign out_ch.y_present = res_q.y_present;
	assign out_ch.y_value = res_q.y_value;
	assign out_ch.z_present = res_q.z_present;
	assign out_ch.z_value = res_q.z_value;
	assign out_ch.f_present = res_q.f_present;
	assign out_ch.f_value = res_q.f_value;
	assign out_ch.error = res_q.error;
endmodule

>>> hdl/gcode_line_parser.sv
// Top level of the G-code line parser.
// The parser takes one character per cycle while its queue has room and returns
// one registered result per line, holding the command, the axis flags and values
// in thousandths, and the first error. A two-entry queue parts the classifying
// front end from the parse state machine, and a result register lets the next
// line's characters flow in while a result waits to be taken; only the next
// line's last character waits for it to empty.
module gcode_line_parser (
	input logic clk,
	input logic arst_n,
	glp_in_if.sink in_ch,
	glp_out_if.source out_ch
);
	import glp_pkg::*;

	tok_t tok;
	logic tok_valid, tok_ready;

	glp_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .tok(tok),
		.tok_valid(tok_valid), .tok_ready(tok_ready));
	glp_back u_back (.clk(clk), .arst_n(arst_n), .tok(tok), .tok_valid(tok_valid),
		.tok_ready(tok_ready), .out_ch(out_ch));
endmodule

>>> hdl/glp_checker.sv
// Port-level checker for the G-code line parser, bound to the top level.
module glp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] command,
	input logic x_present,
	input logic [2:0] error
);
	import glp_pkg::*;

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != ERR_OK |-> command == CMD_GO && !x_present)
		else $error("error result carries fields");
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command <= CMD_REL && error <= ERR_HOME)
		else $error("result code out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error))
		else $error("stalled result changed");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("waiting request dropped");
endmodule

bind gcode_line_parser glp_checker u_glp_checker (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .command(out_ch.command), .x_present(out_ch.x_present),
	.error(out_ch.error));

>>> tb/sv/gcode_line_parser_test.sv
// Testbench for the G-code line parser: random and directed lines checked against a predictor.
`timescale 1ns / 100ps

module gcode_line_parser_test;
	import glp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [32:0] SAT_MAG = 33'h1_0000_0000 >> 1;

	// Line decoder and store of expected results.
	class line_scoreboard;
		phase_t phase;
		int cmd_number;
		bit num_digit, num_neg;
		cmd_t cmd_code;
		logic [7:0] letter;
		int tok_len;
		logic [32:0] mag;
		int frac_cnt;
		bit v_neg, v_digit, v_dot, v_stop, v_start;
		logic [3:0] present;
		logic [31:0] axis_val [4];
		err_t first_err;
		res_t expected_lines [$];
		int errors;

		function void clear();
			phase = PH_LETTER;
			cmd_number = 0;
			num_digit = 0;
			num_neg = 0;
			cmd_code = CMD_GO;
			letter = 0;
			tok_len = 0;
			mag = 0;
			frac_cnt = 0;
			{v_neg, v_digit, v_dot, v_stop, v_start} = 0;
			present = 0;
			foreach (axis_val[k]) axis_val[k] = 0;
			first_err = ERR_OK;
		endfunction

		function logic [32:0] shift_in(logic [32:0] a, int d);
			longint r;
			r = longint'(a) * 10 + d;
			return (r > longint'(SAT_MAG)) ? SAT_MAG : r[32:0];
		endfunction

		function void flag_error(err_t e);
			if (first_err == ERR_OK) first_err = e;
			phase = PH_SKIP;
		endfunction

		function int axis_index(logic [7:0] c);
			case (c)
				"X": return 0;
				"Y": return 1;
				"Z": return 2;
				"F": return 3;
				default: return -1;
			endcase
		endfunction

		// Close the command number and pick the command.
		function void close_number();
			int code;
			code = -1;
			if (!num_digit) begin
				flag_error(ERR_NUMBER);
				return;
			end
			if (!(num_neg && cmd_number != 0)) begin
				case (cmd_number)
					0, 1: code = CMD_GO;
					20: code = CMD_INCHES;
					21: code = CMD_MM;
					28: code = CMD_HOME;
					90: code = CMD_ABS;
					91: code = CMD_REL;
					default: code = -1;
				endcase
			end
			if (code < 0) begin
				flag_error(ERR_UNKNOWN);
				return;
			end
			cmd_code = cmd_t'(code);
			phase = (cmd_code == CMD_GO || cmd_code == CMD_HOME) ? PH_GAP : PH_SKIP;
		endfunction

		function void number_byte(logic [7:0] c);
			if (phase == PH_NUM_STOPPED) return;
			if (phase == PH_NUM_START) begin
				if (c >= 9 && c <= 13) return;
				phase = PH_NUM_DIGITS;
				if (c == "+") return;
				if (c == "-") begin
					num_neg = 1;
					return;
				end
			end
			if (c >= "0" && c <= "9") begin
				num_digit = 1;
				cmd_number = cmd_number * 10 + (c - "0");
				if (cmd_number > 127) cmd_number = 127;
			end else begin
				phase = PH_NUM_STOPPED;
			end
		endfunction

		function void value_byte(logic [7:0] c);
			if (v_stop) return;
			if (!v_start) begin
				if (c >= 9 && c <= 13) return;
				v_start = 1;
				if (c == "+") return;
				if (c == "-") begin
					v_neg = 1;
					return;
				end
			end
			if (c >= "0" && c <= "9") begin
				v_digit = 1;
				if (!v_dot) begin
					mag = shift_in(mag, c - "0");
				end else if (frac_cnt < FRACTION_DIGITS) begin
					mag = shift_in(mag, c - "0");
					frac_cnt++;
				end
			end else if (c == "." && !v_dot) begin
				v_dot = 1;
			end else begin
				v_stop = 1;
			end
		endfunction

		// Close one token after its letter.
		function void close_token();
			int ax;
			logic [32:0] m;
			ax = axis_index(letter);
			phase = PH_GAP;
			if (cmd_code == CMD_HOME) begin
				if (ax < 0 || ax == 3 || tok_len != 0) begin
					flag_error(ERR_HOME);
					return;
				end
				present[ax] = 1;
				axis_val[ax] = 1000;
				return;
			end
			if (ax < 0) return;
			if (tok_len > MAX_VALUE_CHARS) begin
				flag_error(ERR_LONG);
				return;
			end
			if (!v_digit) begin
				flag_error(ERR_VALUE);
				return;
			end
			m = mag;
			for (int k = frac_cnt; k < FRACTION_DIGITS; k++) m = shift_in(m, 0);
			present[ax] = 1;
			if (v_neg) axis_val[ax] = (m >= SAT_MAG) ? 32'h8000_0000 : -m[31:0];
			else axis_val[ax] = (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		endfunction

		// Note one accepted request.
		function void note_request(logic [7:0] c, logic last);
			res_t r;
			case (phase)
				PH_LETTER: begin
					if (c == "G") phase = PH_NUM_START;
					else flag_error(ERR_UNKNOWN);
				end
				PH_NUM_START, PH_NUM_DIGITS, PH_NUM_STOPPED: begin
					if (c == " ") close_number();
					else number_byte(c);
				end
				PH_GAP: begin
					if (c != " ") begin
						letter = c;
						tok_len = 0;
						mag = 0;
						frac_cnt = 0;
						{v_neg, v_digit, v_dot, v_stop, v_start} = 0;
						phase = PH_TOKEN;
					end
				end
				PH_TOKEN: begin
					if (c == " ") begin
						close_token();
					end else begin
						if (tok_len < 255) tok_len++;
						if (cmd_code == CMD_GO) value_byte(c);
					end
				end
				default: ;
			endcase
			if (!last) return;
			if (phase == PH_LETTER) flag_error(ERR_UNKNOWN);
			else if (phase == PH_NUM_START || phase == PH_NUM_DIGITS
					|| phase == PH_NUM_STOPPED) close_number();
			else if (phase == PH_TOKEN) close_token();
			r = '0;
			if (first_err != ERR_OK) begin
				r.error = first_err;
			end else begin
				r.command = cmd_code;
				{r.x_present, r.y_present, r.z_present, r.f_present} =
					{present[0], present[1], present[2], present[3]};
				r.x_value = axis_val[0];
				r.y_value = axis_val[1];
				r.z_value = axis_val[2];
				r.f_value = axis_val[3];
			end
			expected_lines.push_back(r);
			clear();
		endfunction

		function void compare(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, e, a);
				errors++;
			end
		endfunction

		// Check one accepted result against the oldest expectation.
		function void check_result(res_t a);
			res_t e;
			if (expected_lines.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %0h", $realtime, a);
				errors++;
				return;
			end
			e = expected_lines.pop_front();
			compare("command", e.command, a.command);
			compare("x_present", e.x_present, a.x_present);
			compare("x_value", e.x_value, a.x_value);
			compare("y_present", e.y_present, a.y_present);
			compare("y_value", e.y_value, a.y_value);
			compare("z_present", e.z_present, a.z_present);
			compare("z_value", e.z_value, a.z_value);
			compare("f_present", e.f_present, a.f_present);
			compare("f_value", e.f_value, a.f_value);
			compare("error", e.error, a.error);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int cycles;
	int items_sent;
	bit stall_request;
	bit stall_done;
	line_scoreboard lines;

	glp_in_if in_ch (clk);
	glp_out_if out_ch (clk);

	gcode_line_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	// Idle lengths: mostly none or short, now and then long.
	function automatic int idle_len();
		int p;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("gcode_line_parser_test: done, errors");
			$finish;
		end
	end

	// Result side: random ready, one long hold-off on request, check on accept.
	initial begin
		int hold;
		hold = 0;
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready = 0;
			end else if ($urandom_range(9) == 0) begin
				out_ch.ready = 0;
				hold = idle_len();
			end else begin
				out_ch.ready = 1;
			end
		end
	end

	always @(posedge clk) begin
		res_t a;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			a.command = out_ch.command;
			a.x_present = out_ch.x_present;
			a.x_value = out_ch.x_value;
			a.y_present = out_ch.y_present;
			a.y_value = out_ch.y_value;
			a.z_present = out_ch.z_present;
			a.z_value = out_ch.z_value;
			a.f_present = out_ch.f_present;
			a.f_value = out_ch.f_value;
			a.error = out_ch.error;
			lines.check_result(a);
		end
	end

	// Send one line, a request per character, last on the final one.
	task automatic send_line(input logic [7:0] text [$], input bit no_gaps);
		int g;
		for (int i = 0; i < text.size(); i++) begin
			g = no_gaps ? 0 : idle_len();
			if (g > 0) begin
				in_ch.valid = 0;
				repeat (g) @(negedge clk);
			end
			in_ch.valid = 1;
			in_ch.byte_in = text[i];
			in_ch.last = (i == text.size() - 1);
			do @(posedge clk); while (!in_ch.ready);
			lines.note_request(text[i], i == text.size() - 1);
			items_sent++;
			@(negedge clk);
		end
		in_ch.valid = 0;
	endtask

	task automatic send_text(input string s);
		logic [7:0] t [$];
		foreach (s[i]) t.push_back(s[i]);
		send_line(t, 0);
	endtask

	function automatic void add_digits(ref logic [7:0] t [$], input int n);
		repeat (n) t.push_back(8'("0" + $urandom_range(9)));
	endfunction

	// Random well-formed command line, with a little damage now and then.
	task automatic send_random_line();
		logic [7:0] t [$];
		int kind, n;
		byte axes [5];
		axes = '{"X", "Y", "Z", "F", "Q"};
		kind = $urandom_range(99);
		if (kind < 8) begin
			// Noise over the whole byte range.
			n = $urandom_range(1, 12);
			repeat (n) t.push_back(8'($urandom_range(255)));
		end else if (kind < 20) begin
			t = '{"G"};
			case ($urandom_range(7))
				0: t.push_back(8'("0" + $urandom_range(1)));
				1: begin t.push_back("2"); t.push_back("0"); end
				2: begin t.push_back("2"); t.push_back("1"); end
				3: begin t.push_back("9"); t.push_back("0"); end
				4: begin t.push_back("9"); t.push_back("1"); end
				5: t.push_back("-");
				default: add_digits(t, $urandom_range(1, 4));
			endcase
			if ($urandom_range(1)) begin
				t.push_back(" ");
				repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(32, 126)));
			end
		end else if (kind < 35) begin
			t = '{"G", "2", "8"};
			repeat ($urandom_range(0, 4)) begin
				t.push_back(" ");
				t.push_back(axes[$urandom_range(($urandom_range(9) == 0) ? 4 : 2)]);
				if ($urandom_range(14) == 0) t.push_back("1");
			end
		end else begin
			t = '{"G"};
			if ($urandom_range(3) == 0) t.push_back("0");
			t.push_back(8'("0" + $urandom_range(1)));
			repeat ($urandom_range(1, 5)) begin
				repeat ($urandom_range(1, 2)) t.push_back(" ");
				t.push_back(axes[$urandom_range(($urandom_range(7) == 0) ? 4 : 3)]);
				if ($urandom_range(9) == 0) t.push_back(8'(9 + $urandom_range(4)));
				case ($urandom_range(3))
					0: t.push_back("-");
					1: t.push_back("+");
					default: ;
				endcase
				add_digits(t, $urandom_range(($urandom_range(9) == 0) ? 0 : 1,
					($urandom_range(9) == 0) ? 12 : 4));
				if ($urandom_range(1)) begin
					t.push_back(".");
					add_digits(t, $urandom_range(0, 5));
				end
				if ($urandom_range(11) == 0) t.push_back(8'($urandom_range(33, 126)));
			end
		end
		send_line(t, $urandom_range(4) == 0);
	endtask

	initial begin
		logic [7:0] long_tok [$];
		lines = new();
		lines.clear();
		in_ch.valid = 0;
		in_ch.byte_in = 0;
		in_ch.last = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed lines: every command, the value forms and each error.
		send_text("G0 X1.5 Y-2 Z+0.0009 F100");
		send_text("G1 X2147483.647 Y-2147483.648 Z99999999999 F-99999999999");
		send_text("G20");
		send_text("G21 junk");
		send_text("G28 X Y Z");
		send_text("G28 F");
		send_text("G28 X1");
		send_text("G90");
		send_text("G91x");
		send_text("M3");
		send_text("G");
		send_text("G X1");
		send_text("G-0 X1");
		send_text("G-1");
		send_text("G\t+999 X1");
		send_text("G0 Xabc");
		send_text("G0 X");
		send_text("G0 Q5 X1 X2 Z.5 Y-.");
		send_text("G0 X\t-1.2.3");
		send_text("G01  X12  F7  ");
		long_tok = '{"G", "0", " ", "X"};
		repeat (70) long_tok.push_back("1");
		send_line(long_tok, 0);

		// Random lines, with one long hold-off on the result side.
		while (items_sent < 1150) begin
			if (items_sent > 500 && !stall_done) begin
				stall_request = 1;
				stall_done = 1;
			end
			send_random_line();
		end

		while (lines.expected_lines.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (lines.errors == 0 && lines.expected_lines.size() == 0) begin
			$display("gcode_line_parser_test: done, clean");
		end else begin
			$display("gcode_line_parser_test: done, errors");
		end
		$finish;
	end

endmodule
